/* hdl/set_assoc_lru_cache_sim_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the LRU cache simulator
// Clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_LRU_CACHE_SIM_MACROS_SVH
`define SET_ASSOC_LRU_CACHE_SIM_MACROS_SVH

// Condition that holds at every clock edge.
`define SALC_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// Condition that holds in the same cycle as its trigger.
`define SALC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Condition that holds in the cycle after its trigger.
`define SALC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/salc_pkg.sv */
// ----------------------------------------------------------------------------
// salc_pkg
// Types, constants and codes shared by the LRU cache simulator modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package salc_pkg;

  localparam int MAX_SET_BITS = 6;
  localparam int MAX_WAYS     = 8;
  localparam int ADDR_WIDTH   = 32;

  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int SET_IW   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int SB_W     = (MAX_SET_BITS > 0) ? $clog2(MAX_SET_BITS + 1) : 1;
  localparam int AGE_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WAY_IW   = AGE_W;
  localparam int WCNT_W   = $clog2(MAX_WAYS + 1);
  localparam int TAG_W    = ADDR_WIDTH;
  localparam int TOTAL_W  = 32;

  localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(MAX_WAYS - 1);

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_STORE  = 2'd1,
    OP_MODIFY = 2'd2,
    OP_FETCH  = 2'd3
  } salc_op_e;

  typedef enum logic [1:0] {
    CFG_SET_BITS   = 2'd0,
    CFG_WAYS       = 2'd1,
    CFG_BLOCK_BITS = 2'd2
  } salc_cfg_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK
  } salc_state_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] address;
  } salc_in_t;

  typedef struct packed {
    logic [1:0]         hit_count;
    logic               miss_count;
    logic               evict_count;
    logic [TOTAL_W-1:0] total_hits;
    logic [TOTAL_W-1:0] total_misses;
    logic [TOTAL_W-1:0] total_evictions;
  } salc_out_t;

  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
    logic [AGE_W-1:0] age;
  } salc_way_t;

  typedef salc_way_t [MAX_WAYS-1:0] salc_row_t;

  localparam int ROW_W = $bits(salc_row_t);

  // Outcome of one lookup; exactly one bit is set.
  typedef struct packed {
    logic hit;
    logic fill;
    logic evict;
  } salc_look_t;

endpackage

/* hdl/salc_ram.sv */
// ----------------------------------------------------------------------------
// salc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/salc_update.sv */
// ----------------------------------------------------------------------------
// salc_update
// Tag compare, way selection and LRU age update for one set row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module salc_update
  import salc_pkg::*;
(
  input  salc_row_t         row_i,
  input  logic [TAG_W-1:0]  tag_i,
  input  logic [WCNT_W-1:0] nw_i,
  output salc_row_t         row_o,
  output salc_look_t        look_o
);

  logic [MAX_WAYS-1:0] in_range;
  logic                hit_found;
  logic [WAY_IW-1:0]   hit_way;
  logic                free_found;
  logic [WAY_IW-1:0]   free_way;
  logic [WAY_IW-1:0]   victim;
  logic [AGE_W-1:0]    oldest;
  logic [WAY_IW-1:0]   sel_way;
  logic [AGE_W:0]      limit;

  always_comb begin
    hit_found  = 1'b0;
    hit_way    = '0;
    free_found = 1'b0;
    free_way   = '0;
    victim     = '0;
    oldest     = row_i[0].age;
    for (int i = 0; i < MAX_WAYS; i++) begin
      in_range[i] = (WCNT_W'(i) < nw_i);
    end
    // Scan downward so that the lowest matching or free way wins.
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (in_range[i] && row_i[i].valid && (row_i[i].tag == tag_i)) begin
        hit_found = 1'b1;
        hit_way   = WAY_IW'(i);
      end
      if (in_range[i] && !row_i[i].valid) begin
        free_found = 1'b1;
        free_way   = WAY_IW'(i);
      end
    end
    // Among equal ages the highest way in use is the victim.
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (in_range[i] && (oldest <= row_i[i].age)) begin
        oldest = row_i[i].age;
        victim = WAY_IW'(i);
      end
    end

    if (hit_found) begin
      sel_way = hit_way;
      limit   = {1'b0, row_i[hit_way].age};
    end else begin
      sel_way = free_found ? free_way : victim;
      limit   = {1'b0, AGE_MAX} + (AGE_W + 1)'(1);
    end

    row_o = row_i;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (WAY_IW'(i) == sel_way) begin
        row_o[i].age = '0;
        if (!hit_found) begin
          row_o[i].valid = 1'b1;
          row_o[i].tag   = tag_i;
        end
      end else if (in_range[i] && row_i[i].valid && ({1'b0, row_i[i].age} < limit) &&
                   (row_i[i].age < AGE_MAX)) begin
        row_o[i].age = row_i[i].age + AGE_W'(1);
      end
    end

    look_o.hit   = hit_found;
    look_o.fill  = !hit_found && free_found;
    look_o.evict = !hit_found && !free_found;
  end

endmodule

/* hdl/set_assoc_lru_cache_sim.sv */
// The set row of an accepted item is read into the RAM output register; the result
// is registered from the lookup state once the output slot is free, together with the
// write-back of the row; no new item is taken before then. An instruction fetch gives no result.
// A modify costs the same as a load: its second access always hits the line just used.
// Reset: the state, counter and setting registers take their reset values at once,
// then a pass clears all 64 set rows of the RAM; no item is accepted during that pass.
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_sim
// Tag-only set-associative cache with true LRU replacement and hit, miss and
// eviction counters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "set_assoc_lru_cache_sim_macros.svh"

module set_assoc_lru_cache_sim
  import salc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [4:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  salc_in_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output salc_out_t   out_data_o
);

  salc_state_e state_q, state_d;

  logic [2:0] set_bits_q;
  logic [3:0] ways_q;
  logic [4:0] block_bits_q;

  logic [SET_IW-1:0]  clr_q, clr_d;
  logic [SET_IW-1:0]  set_q;
  logic [TAG_W-1:0]   tag_q;
  logic               mod_q;
  logic [TOTAL_W-1:0] hits_q, misses_q, evicts_q;
  logic               out_valid_q;
  salc_out_t          out_q;

  logic               in_acc;
  logic               out_free;
  logic               finish;
  logic [SB_W-1:0]    sb;
  logic [WCNT_W-1:0]  nw;
  logic [TAG_W-1:0]   addr_ext;
  logic [TAG_W-1:0]   blk;
  logic [SET_IW-1:0]  set_idx;
  logic [TAG_W-1:0]   tag_d;
  logic               ram_we;
  logic               ram_re;
  logic [SET_IW-1:0]  ram_waddr;
  salc_row_t          ram_wdata;
  salc_row_t          ram_rdata;
  salc_row_t          new_row;
  salc_look_t         look;
  logic [1:0]         hit_cnt;
  logic [TOTAL_W:0]   hits_sum, misses_sum, evicts_sum;
  logic [TOTAL_W-1:0] hits_d, misses_d, evicts_d;
  logic [2:0]         look_vec;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // Address split.
  always_comb begin
    sb       = (int'(set_bits_q) > MAX_SET_BITS) ? SB_W'(MAX_SET_BITS) : SB_W'(set_bits_q);
    addr_ext = TAG_W'(in_data_i.address);
    blk      = (int'(block_bits_q) >= ADDR_WIDTH) ? '0 : (addr_ext >> block_bits_q);
    set_idx  = blk[SET_IW-1:0] & ~({SET_IW{1'b1}} << sb);
    tag_d    = blk >> sb;
  end

  always_comb begin
    if (ways_q == 4'd0) begin
      nw = WCNT_W'(1);
    end else if (int'(ways_q) > MAX_WAYS) begin
      nw = WCNT_W'(MAX_WAYS);
    end else begin
      nw = WCNT_W'(ways_q);
    end
  end

  salc_ram #(
    .WIDTH(ROW_W),
    .DEPTH(NUM_SETS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(set_idx),
    .rdata_o(ram_rdata)
  );

  salc_update u_update (
    .row_i (ram_rdata),
    .tag_i (tag_q),
    .nw_i  (nw),
    .row_o (new_row),
    .look_o(look)
  );

  // Counts and saturating totals.
  always_comb begin
    hit_cnt    = 2'(look.hit) + 2'(mod_q);
    hits_sum   = {1'b0, hits_q} + (TOTAL_W + 1)'(hit_cnt);
    misses_sum = {1'b0, misses_q} + (TOTAL_W + 1)'(look.fill || look.evict);
    evicts_sum = {1'b0, evicts_q} + (TOTAL_W + 1)'(look.evict);
    hits_d     = hits_sum[TOTAL_W] ? '1 : hits_sum[TOTAL_W-1:0];
    misses_d   = misses_sum[TOTAL_W] ? '1 : misses_sum[TOTAL_W-1:0];
    evicts_d   = evicts_sum[TOTAL_W] ? '1 : evicts_sum[TOTAL_W-1:0];
  end

  // Sequencer. The row read at accept stays in the RAM output register while
  // the result waits for a free output slot, and it is written back only once.
  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    in_stall_o = 1'b1;
    finish     = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = set_q;
    ram_wdata  = new_row;
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + SET_IW'(1);
        if (clr_q == SET_IW'(NUM_SETS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_acc && (in_data_i.opcode != OP_FETCH)) begin
          ram_re  = 1'b1;
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (out_free) begin
          finish  = 1'b1;
          ram_we  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_q        <= '0;
      set_bits_q   <= 3'd4;
      ways_q       <= 4'd1;
      block_bits_q <= 5'd4;
      hits_q       <= '0;
      misses_q     <= '0;
      evicts_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SET_BITS:   set_bits_q   <= cfg_wdata_i[2:0];
          CFG_WAYS:       ways_q       <= cfg_wdata_i[3:0];
          CFG_BLOCK_BITS: block_bits_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (finish) begin
        hits_q      <= hits_d;
        misses_q    <= misses_d;
        evicts_q    <= evicts_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_re) begin
      set_q <= set_idx;
      tag_q <= tag_d;
      mod_q <= (in_data_i.opcode == OP_MODIFY);
    end
    if (finish) begin
      out_q.hit_count       <= hit_cnt;
      out_q.miss_count      <= look.fill || look.evict;
      out_q.evict_count     <= look.evict;
      out_q.total_hits      <= hits_d;
      out_q.total_misses    <= misses_d;
      out_q.total_evictions <= evicts_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign look_vec = {look.hit, look.fill, look.evict};

  `SALC_ASSERT_IMP(a_no_accept_in_clear, state_q == ST_CLEAR, in_stall_o,
                   "item accepted during the clearing pass")
  `SALC_ASSERT_IMP(a_one_outcome, state_q == ST_LOOK, $onehot(look_vec),
                   "lookup outcome is not exactly one of hit, fill, evict")
  `SALC_ASSERT_NXT(a_access_looks, in_acc && (in_data_i.opcode != OP_FETCH),
                   state_q == ST_LOOK, "accepted access did not start a lookup")
  `SALC_ASSERT_IMP(a_finish_slot_free, finish, out_free,
                   "result written while the output register is still held")
  `SALC_ASSERT_IMP(a_hit_count_range, out_valid_q, out_q.hit_count != 2'd3,
                   "hit count out of range")

endmodule

/* test/salc_checker.sv */
// ----------------------------------------------------------------------------
// salc_checker
// Watches the configuration port and both item channels of the LRU cache
// simulator, keeps its own copy of the tag store, ages and totals, and
// compares every result leaving the block with the one it predicted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module salc_checker
  import salc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [4:0] cfg_wdata_i,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  salc_in_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  salc_out_t out_data_i,
  output int        errors_o,
  output int        pending_o
);

  localparam int NUM_LINES = NUM_SETS * MAX_WAYS;

  logic             line_ok   [NUM_LINES];
  logic [TAG_W-1:0] line_tag  [NUM_LINES];
  logic [AGE_W-1:0] line_rank [NUM_LINES];

  logic [2:0] set_bits_q;
  logic [3:0] ways_q;
  logic [4:0] block_bits_q;

  logic [TOTAL_W-1:0] hits_total;
  logic [TOTAL_W-1:0] misses_total;
  logic [TOTAL_W-1:0] evicts_total;

  salc_out_t due_results[$];

  int        item_hits;
  int        item_misses;
  int        item_evicts;
  salc_out_t want;

  function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a, input int b);
    return (a > {TOTAL_W{1'b1}} - TOTAL_W'(b)) ? {TOTAL_W{1'b1}} : a + TOTAL_W'(b);
  endfunction

  // Way w becomes most recent; other valid ways younger than limit age by one.
  task automatic make_recent(input int base, input int nw, input int w, input int limit);
    int k;
    for (int i = 0; i < nw; i++) begin
      k = base + i;
      if (i != w && line_ok[k] && int'(line_rank[k]) < limit && line_rank[k] < AGE_MAX) begin
        line_rank[k] = line_rank[k] + 1'b1;
      end
    end
    line_rank[base + w] = '0;
  endtask

  task automatic cache_access(input logic [31:0] addr, inout int hits, inout int misses,
                              inout int evicts);
    int               sb;
    int               nw;
    int               base;
    int               victim;
    int               k;
    logic [63:0]      blk;
    logic [TAG_W-1:0] tag;
    logic [AGE_W-1:0] oldest;
    sb   = (set_bits_q > MAX_SET_BITS) ? MAX_SET_BITS : int'(set_bits_q);
    nw   = (ways_q == 0) ? 1 : ((ways_q > MAX_WAYS) ? MAX_WAYS : int'(ways_q));
    blk  = (block_bits_q >= ADDR_WIDTH) ? 64'd0 : ({32'd0, addr} >> block_bits_q);
    base = int'(blk & ((64'd1 << sb) - 64'd1)) * MAX_WAYS;
    tag  = TAG_W'(blk >> sb);
    for (int i = 0; i < nw; i++) begin
      k = base + i;
      if (line_ok[k] && line_tag[k] == tag) begin
        make_recent(base, nw, i, int'(line_rank[k]));
        hits++;
        return;
      end
    end
    misses++;
    for (int i = 0; i < nw; i++) begin
      k = base + i;
      if (!line_ok[k]) begin
        line_ok[k]  = 1'b1;
        line_tag[k] = tag;
        make_recent(base, nw, i, int'(AGE_MAX) + 1);
        return;
      end
    end
    evicts++;
    // Among equal ages the highest-numbered way loses.
    victim = 0;
    oldest = line_rank[base];
    for (int i = 0; i < nw; i++) begin
      if (oldest <= line_rank[base + i]) begin
        oldest = line_rank[base + i];
        victim = i;
      end
    end
    line_tag[base + victim] = tag;
    make_recent(base, nw, victim, int'(AGE_MAX) + 1);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_LINES; k++) begin
        line_ok[k]   = 1'b0;
        line_tag[k]  = '0;
        line_rank[k] = '0;
      end
      set_bits_q   = 3'd4;
      ways_q       = 4'd1;
      block_bits_q = 5'd4;
      hits_total   = '0;
      misses_total = '0;
      evicts_total = '0;
      due_results.delete();
      errors_o  = 0;
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (due_results.size() == 0) begin
          errors_o++;
          if (errors_o <= 10) begin
            $display("%0t: result with none expected: hit %0d miss %0d evict %0d totals %0d %0d %0d",
                     $realtime, out_data_i.hit_count, out_data_i.miss_count,
                     out_data_i.evict_count, out_data_i.total_hits, out_data_i.total_misses,
                     out_data_i.total_evictions);
          end
        end else begin
          want = due_results.pop_front();
          if (out_data_i.hit_count !== want.hit_count ||
              out_data_i.miss_count !== want.miss_count ||
              out_data_i.evict_count !== want.evict_count ||
              out_data_i.total_hits !== want.total_hits ||
              out_data_i.total_misses !== want.total_misses ||
              out_data_i.total_evictions !== want.total_evictions) begin
            errors_o++;
            if (errors_o <= 10) begin
              $display("%0t: mismatch: hit %0d/%0d miss %0d/%0d evict %0d/%0d (expected/actual)",
                       $realtime, want.hit_count, out_data_i.hit_count, want.miss_count,
                       out_data_i.miss_count, want.evict_count, out_data_i.evict_count);
              $display("  totals expected %0d %0d %0d, actual %0d %0d %0d",
                       want.total_hits, want.total_misses, want.total_evictions,
                       out_data_i.total_hits, out_data_i.total_misses,
                       out_data_i.total_evictions);
            end
          end
        end
      end

      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SET_BITS:   set_bits_q   = cfg_wdata_i[2:0];
          CFG_WAYS:       ways_q       = cfg_wdata_i[3:0];
          CFG_BLOCK_BITS: block_bits_q = cfg_wdata_i[4:0];
          default: ;
        endcase
      end

      if (in_valid_i && !in_stall_i && in_data_i.opcode != OP_FETCH) begin
        item_hits   = 0;
        item_misses = 0;
        item_evicts = 0;
        cache_access(in_data_i.address, item_hits, item_misses, item_evicts);
        // A modify is a second access to the same address.
        if (in_data_i.opcode == OP_MODIFY) begin
          cache_access(in_data_i.address, item_hits, item_misses, item_evicts);
        end
        hits_total   = sat_add(hits_total, item_hits);
        misses_total = sat_add(misses_total, item_misses);
        evicts_total = sat_add(evicts_total, item_evicts);
        want.hit_count       = 2'(item_hits);
        want.miss_count      = 1'(item_misses);
        want.evict_count     = 1'(item_evicts);
        want.total_hits      = hits_total;
        want.total_misses    = misses_total;
        want.total_evictions = evicts_total;
        due_results.push_back(want);
      end
      pending_o = due_results.size();
    end
  end

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Drives the LRU cache simulator with directed accesses and then with phases
// of random accesses drawn mostly from small per-set tag pools, each phase under a
// new register setting, with random idle cycles on both channels and one long
// receiver hold-off. A checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import salc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 140;
  localparam int HOLD_CYCLES = 150;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic [1:0] cfg_idx_i   = '0;
  logic [4:0] cfg_wdata_i = '0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  salc_in_t   in_data_i   = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  salc_out_t  out_data_o;

  int   err_cnt;
  int   open_cnt;
  int   cycle_cnt   = 0;
  logic idle_on     = 1'b1;
  logic squeeze_req = 1'b0;

  // Stimulus-side copy of the setting, used only to aim addresses.
  logic [2:0] cur_sb   = 3'd4;
  logic [3:0] cur_ways = 4'd1;
  logic [4:0] cur_bb   = 5'd4;

  set_assoc_lru_cache_sim dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  salc_checker u_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_i (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_i(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_i (out_data_o),
    .errors_o   (err_cnt),
    .pending_o  (open_cnt)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL set_assoc_lru_cache_sim");
      $finish;
    end
  end

  // Result side: random stalls, or one long hold-off on request.
  initial begin
    logic squeezed;
    squeezed = 1'b0;
    forever begin
      @(negedge clk_i);
      if (squeeze_req && !squeezed) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        squeezed = 1'b1;
      end else begin
        out_stall_i <= idle_on && ($urandom_range(99) < 20);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic put_access(input salc_op_e op, input logic [31:0] addr);
    while (idle_on && $urandom_range(99) < 20) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{opcode: op, address: addr};
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic change_setting(input logic [4:0] sb, input logic [4:0] nw,
                                input logic [4:0] bb);
    in_valid_i <= 1'b0;
    while (open_cnt != 0) @(negedge clk_i);
    // A trailing fetch may still be in flight with nothing expected.
    repeat (4) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_SET_BITS;
    cfg_wdata_i <= sb;
    @(negedge clk_i);
    cfg_idx_i   <= CFG_WAYS;
    cfg_wdata_i <= nw;
    @(negedge clk_i);
    cfg_idx_i   <= CFG_BLOCK_BITS;
    cfg_wdata_i <= bb;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cur_sb   = sb[2:0];
    cur_ways = nw[3:0];
    cur_bb   = bb;
  endtask

  // Mostly addresses from a tag pool a little larger than the ways in use,
  // over a few sets, so that hits, fills and evictions all happen.
  function automatic logic [31:0] pick_address();
    int          sb;
    int          nw;
    int          bb;
    logic [63:0] a;
    sb = (cur_sb > MAX_SET_BITS) ? MAX_SET_BITS : int'(cur_sb);
    nw = (cur_ways == 0) ? 1 : ((cur_ways > MAX_WAYS) ? MAX_WAYS : int'(cur_ways));
    bb = int'(cur_bb);
    if ($urandom_range(99) < 15) return $urandom;
    a = 64'($urandom_range(nw + 1)) << (bb + sb);
    a = a | ((64'($urandom_range(3)) & ((64'd1 << sb) - 64'd1)) << bb);
    a = a | (64'($urandom) & ((64'd1 << bb) - 64'd1));
    return a[31:0];
  endfunction

  function automatic salc_op_e pick_op();
    int r;
    r = $urandom_range(99);
    if (r < 30) return OP_LOAD;
    if (r < 60) return OP_STORE;
    if (r < 90) return OP_MODIFY;
    return OP_FETCH;
  endfunction

  initial begin
    salc_op_e op;
    int       sent;

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset setting: 16 sets, one way, 16-byte blocks.
    put_access(OP_LOAD, 32'h0000_0000);
    put_access(OP_LOAD, 32'h0000_0000);
    put_access(OP_STORE, 32'h0000_000F);
    put_access(OP_MODIFY, 32'h0000_0010);
    put_access(OP_FETCH, 32'h0000_0010);
    put_access(OP_LOAD, 32'h0000_0100);
    put_access(OP_MODIFY, 32'h0000_0000);
    put_access(OP_LOAD, 32'hFFFF_FFFF);
    put_access(OP_STORE, 32'h8000_0000);
    put_access(OP_MODIFY, 32'hFFFF_FFF0);
    put_access(OP_FETCH, 32'hFFFF_FFFF);

    // Set bits and ways beyond their limits, largest offset.
    change_setting(5'd7, 5'd0, 5'd31);
    put_access(OP_LOAD, 32'h0000_0000);
    put_access(OP_MODIFY, 32'h8000_0000);
    put_access(OP_LOAD, 32'h7FFF_FFFF);

    // One set of eight ways: fill it, refresh the first line, then evict.
    change_setting(5'd0, 5'd15, 5'd0);
    for (int i = 0; i < 8; i++) put_access(OP_LOAD, 32'(i));
    put_access(OP_LOAD, 32'd0);
    put_access(OP_LOAD, 32'd8);
    put_access(OP_LOAD, 32'd1);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       change_setting(5'd0, 5'd1, 5'd0);
        1:       change_setting(5'd6, 5'd8, 5'd26);
        2:       change_setting(5'd7, 5'd15, 5'd31);
        3:       change_setting(5'd0, 5'd0, 5'd5);
        default: change_setting(5'($urandom_range(7)), 5'($urandom_range(15)),
                                5'($urandom_range(31)));
      endcase
      idle_on = (p != 3 && p != 5);
      // The receiver holds off while items keep coming, so the block backs up.
      if (p == 5) squeeze_req = 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        op = pick_op();
        put_access(op, pick_address());
        sent++;
      end
    end

    in_valid_i <= 1'b0;
    idle_on = 1'b1;
    while (open_cnt != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("PASS set_assoc_lru_cache_sim");
    end else begin
      $display("FAIL set_assoc_lru_cache_sim");
    end
    $finish;
  end

endmodule
